// ===== rtl/urd_pkg.sv =====
// shared types and constants for the unsigned restoring divider
`timescale 1ns / 1ps

package urd_pkg;

   // width of every operand and result field on the channels
   localparam int FIELD_WIDTH = 32;

   typedef logic [FIELD_WIDTH-1:0] field_type;

endpackage

// ===== rtl/urd_req_if.sv =====
// request channel: dividend and divisor with valid/ready handshake
`timescale 1ns / 1ps

interface urd_req_if;
   logic                valid;
   logic                ready;
   urd_pkg::field_type  dividend;
   urd_pkg::field_type  divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ===== rtl/urd_rsp_if.sv =====
// response channel: quotient and remainder with valid/ready handshake
`timescale 1ns / 1ps

interface urd_rsp_if;
   logic                valid;
   logic                ready;
   urd_pkg::field_type  quotient;
   urd_pkg::field_type  remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/unsigned_restoring_divider.sv =====
// unsigned restoring divider, pipelined with a stage for each quotient bit
//
//   channel   direction  payload                 handshake
//   req_ch    in         dividend, divisor       valid / ready
//   rsp_ch    out        quotient, remainder     valid / ready
//
// one request enters per cycle while the first stage is ready; its result moves
// through the stage registers in order and is offered from the last stage,
// one stage for each quotient bit, each stage a single trial subtract.
// sustained rate is one request per cycle while the response side takes.
// reset clears only the stage valid bits.
// each stage holds its request when the next one is full and stalled, and an
// empty stage still takes a new request, so bubbles close up under stall.
`timescale 1ns / 1ps

module unsigned_restoring_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   urd_req_if.sink   req_ch,
   urd_rsp_if.source rsp_ch
);

   localparam int FW = urd_pkg::FIELD_WIDTH;

   logic                  valid_s    [0:DATA_WIDTH];
   logic                  ready_s    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s      [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_s      [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] div_s      [0:DATA_WIDTH];
   logic                  div_zero_s [0:DATA_WIDTH];

   logic [FW+DATA_WIDTH-1:0] dividend_wide;
   logic [FW+DATA_WIDTH-1:0] divisor_wide;
   logic [FW+DATA_WIDTH-1:0] quo_wide;
   logic [FW+DATA_WIDTH-1:0] rem_wide;

   // fit the request fields to the datapath width
   assign dividend_wide = {{DATA_WIDTH{1'b0}}, req_ch.dividend};
   assign divisor_wide  = {{DATA_WIDTH{1'b0}}, req_ch.divisor};

   // head of the pipeline: remainder starts at zero
   assign valid_s[0]    = req_ch.valid;
   assign req_ch.ready  = ready_s[0];
   assign rem_s[0]      = '0;
   assign quo_s[0]      = dividend_wide[DATA_WIDTH-1:0];
   assign div_s[0]      = divisor_wide[DATA_WIDTH-1:0];
   assign div_zero_s[0] = (divisor_wide[DATA_WIDTH-1:0] == '0);

   // one step per stage
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      urd_stage #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .up_valid    (valid_s[i]),
         .up_ready    (ready_s[i]),
         .up_rem      (rem_s[i]),
         .up_quo      (quo_s[i]),
         .up_div      (div_s[i]),
         .up_div_zero (div_zero_s[i]),
         .dn_valid    (valid_s[i+1]),
         .dn_ready    (ready_s[i+1]),
         .dn_rem      (rem_s[i+1]),
         .dn_quo      (quo_s[i+1]),
         .dn_div      (div_s[i+1]),
         .dn_div_zero (div_zero_s[i+1])
      );
   end

   // zero divisor forces both results to zero
   assign quo_wide = {{FW{1'b0}},
                      (div_zero_s[DATA_WIDTH] ? {DATA_WIDTH{1'b0}} : quo_s[DATA_WIDTH])};
   assign rem_wide = {{FW{1'b0}},
                      (div_zero_s[DATA_WIDTH] ? {DATA_WIDTH{1'b0}} : rem_s[DATA_WIDTH])};

   // response side
   assign ready_s[DATA_WIDTH] = rsp_ch.ready;
   assign rsp_ch.valid        = valid_s[DATA_WIDTH];
   assign rsp_ch.quotient     = quo_wide[FW-1:0];
   assign rsp_ch.remainder    = rem_wide[FW-1:0];

   // final remainder always below a nonzero divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_s[DATA_WIDTH] && !div_zero_s[DATA_WIDTH]
         |-> rem_s[DATA_WIDTH] < div_s[DATA_WIDTH])
      else $error("remainder not below divisor");

   // an accepted request occupies the first stage on the next cycle
   a_entry_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_s[1])
      else $error("accepted request lost at first stage");

   // a stalled result stays in the last stage with its payload
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      valid_s[DATA_WIDTH] && !rsp_ch.ready
         |=> valid_s[DATA_WIDTH] && $stable(quo_s[DATA_WIDTH])
             && $stable(rem_s[DATA_WIDTH]))
      else $error("stalled result changed");

endmodule

// ===== rtl/urd_stage.sv =====
// one restoring division step with its pipeline register
`timescale 1ns / 1ps

module urd_stage #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // upstream side
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [DATA_WIDTH-1:0] up_rem,
   input  logic [DATA_WIDTH-1:0] up_quo,
   input  logic [DATA_WIDTH-1:0] up_div,
   input  logic                  up_div_zero,
   // downstream side
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [DATA_WIDTH-1:0] dn_rem,
   output logic [DATA_WIDTH-1:0] dn_quo,
   output logic [DATA_WIDTH-1:0] dn_div,
   output logic                  dn_div_zero
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff;
   logic                  div_zero_ff;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   // shift in the next dividend bit and trial-subtract the divisor
   always_comb begin
      shifted = {up_rem, up_quo[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, up_div};
      fits    = ~diff[DATA_WIDTH];
      rem_in  = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_in  = {up_quo[DATA_WIDTH-2:0], fits};
   end

   // stage takes a request when empty or when its content moves on
   assign up_ready = ~valid_ff | dn_ready;

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
         div_ff      <= up_div;
         div_zero_ff <= up_div_zero;
      end
   end

   assign dn_valid    = valid_ff;
   assign dn_rem      = rem_ff;
   assign dn_quo      = quo_ff;
   assign dn_div      = div_ff;
   assign dn_div_zero = div_zero_ff;

endmodule

// ===== verif/urd_divide_checker.sv =====
// checker for the unsigned restoring divider: predicts and compares every division
`timescale 1ns / 1ps

module urd_divide_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   urd_req_if   req_mon,
   urd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   divisions_checked,
   output int   zero_divisors,
   output int   stalled_cycles
);

   typedef struct packed {
      urd_pkg::field_type quotient;
      urd_pkg::field_type remainder;
   } division_result_type;

   division_result_type pending_divisions[$];
   division_result_type expected;
   int fails = 0;
   int checked = 0;
   int zeros = 0;
   int stalls = 0;

   assign fail_count        = fails;
   assign pending_count     = pending_divisions.size();
   assign divisions_checked = checked;
   assign zero_divisors     = zeros;
   assign stalled_cycles    = stalls;

   // radix-2 restoring division, msb first, keeping the bit shifted out on top
   function automatic division_result_type restoring_divide(
      urd_pkg::field_type num_in,
      urd_pkg::field_type den_in
   );
      logic [DATA_WIDTH-1:0] num;
      logic [DATA_WIDTH-1:0] den;
      logic [DATA_WIDTH-1:0] part_rem;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH:0]   shifted;
      division_result_type   res;
      int                    i;
      num      = DATA_WIDTH'(num_in);
      den      = DATA_WIDTH'(den_in);
      quo      = '0;
      part_rem = '0;
      res      = '0;
      // a zero divisor yields zero quotient and remainder, no flag
      if (den == '0) begin
         return res;
      end
      for (i = DATA_WIDTH - 1; i >= 0; i--) begin
         shifted = {part_rem, num[i]};
         // a set carry bit means the divisor always fits
         if (shifted >= {1'b0, den}) begin
            part_rem = DATA_WIDTH'(shifted - {1'b0, den});
            quo[i]   = 1'b1;
         end else begin
            part_rem = shifted[DATA_WIDTH-1:0];
         end
      end
      res.quotient  = urd_pkg::FIELD_WIDTH'(quo);
      res.remainder = urd_pkg::FIELD_WIDTH'(part_rem);
      return res;
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         // accepted request: queue its prediction
         if (req_mon.valid && req_mon.ready) begin
            pending_divisions.push_back(restoring_divide(req_mon.dividend, req_mon.divisor));
            if (req_mon.divisor == '0) zeros++;
         end
         if (req_mon.valid && !req_mon.ready) stalls++;
         // accepted result: compare against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_divisions.size() == 0) begin
               $error("result with no request outstanding: quotient %0h remainder %0h",
                      rsp_mon.quotient, rsp_mon.remainder);
               fails++;
            end else begin
               expected = pending_divisions.pop_front();
               checked++;
               if (rsp_mon.quotient !== expected.quotient) begin
                  $error("quotient mismatch: expected %0h actual %0h",
                         expected.quotient, rsp_mon.quotient);
                  fails++;
               end
               if (rsp_mon.remainder !== expected.remainder) begin
                  $error("remainder mismatch: expected %0h actual %0h",
                         expected.remainder, rsp_mon.remainder);
                  fails++;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_unsigned_restoring_divider.sv =====
// testbench top for the unsigned restoring divider: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_unsigned_restoring_divider;

   localparam int DATA_WIDTH   = 32;
   localparam int RANDOM_ITEMS = 750;
   localparam int MAX_GAP      = 13;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * DATA_WIDTH;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_DIRECTED = 22;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   int   divisions_checked;
   int   zero_divisors;
   int   stalled_cycles;
   bit   hold_rsp    = 1'b0;
   bit   rsp_bursty  = 1'b0;
   bit   req_bursty  = 1'b0;

   urd_req_if req_ch();
   urd_rsp_if rsp_ch();

   unsigned_restoring_divider #(.DATA_WIDTH(DATA_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   urd_divide_checker #(.DATA_WIDTH(DATA_WIDTH)) checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .divisions_checked (divisions_checked),
      .zero_divisors     (zero_divisors),
      .stalled_cycles    (stalled_cycles)
   );

   // 100 MHz clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("unsigned_restoring_divider test failed");
         $finish;
      end
   end

   // operand with a spread of magnitudes and top-bit patterns
   function automatic urd_pkg::field_type random_operand();
      int                 shape;
      urd_pkg::field_type v;
      shape = $urandom_range(0, 9);
      v     = $urandom;
      case (shape)
         0: v = '1;
         1: v = v | {1'b1, {(urd_pkg::FIELD_WIDTH-1){1'b0}}};
         2, 3, 4: v = v >> $urandom_range(1, urd_pkg::FIELD_WIDTH - 1);
         default: ;
      endcase
      return v;
   endfunction

   // offer one request after an idle gap and hold it until taken
   task automatic send_division(input urd_pkg::field_type num,
                                input urd_pkg::field_type den, input int gap);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.dividend = num;
      req_ch.divisor  = den;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // result side flow control, with one long hold-off on request
   task automatic drain_results();
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = rsp_bursty ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
         taken++;
         if (taken % 37 == 0) rsp_bursty = ($urandom_range(0, 2) == 0);
      end
   endtask

   // wait until every predicted result has come back
   task automatic wait_quiet();
      req_ch.valid = 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   initial begin
      urd_pkg::field_type dir_num [NUM_DIRECTED];
      urd_pkg::field_type dir_den [NUM_DIRECTED];
      urd_pkg::field_type num;
      urd_pkg::field_type den;
      int                 gap;
      int                 burst_left;

      req_ch.valid    = 1'b0;
      req_ch.dividend = '0;
      req_ch.divisor  = '0;
      rsp_ch.ready    = 1'b0;
      reset           = 1'b1;
      burst_left      = 0;

      // extremes, zero divisor, equal operands and top-bit carry cases
      dir_num = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                  32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd5, 32'd100, 32'h8000_0000,
                  32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'd7,
                  32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hC000_0001};
      dir_den = '{32'h0, 32'h1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd3, 32'd7, 32'h1,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h0, 32'd7,
                  32'd7, 32'd2, 32'd3, 32'h1, 32'hA000_0001};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         drain_results();
      join_none

      // directed part
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_division(dir_num[i], dir_den[i], $urandom_range(0, MAX_GAP));
      wait_quiet();

      // random part
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // long result stall while requests keep coming back to back
         if (i == 200) begin
            hold_rsp   = 1'b1;
            burst_left = 80;
         end
         // sender pause until the pipeline is empty
         if (i == 450) wait_quiet();
         if (i % 50 == 0 && burst_left == 0) req_bursty = ($urandom_range(0, 3) == 0);
         gap = (burst_left > 0 || req_bursty) ? 0 : $urandom_range(0, MAX_GAP);
         if (burst_left > 0) burst_left--;
         den = ($urandom_range(0, 15) == 0) ? urd_pkg::field_type'(0) : random_operand();
         num = random_operand();
         send_division(num, den, gap);
      end
      req_ch.valid = 1'b0;

      // let anything stray come out
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d divisions (%0d by zero), request side stalled %0d cycles",
               divisions_checked, zero_divisors, stalled_cycles);
      $display("random gaps on both sides, one long result hold-off, one full drain");
      if (fail_count == 0) begin
         $display("unsigned_restoring_divider test passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("unsigned_restoring_divider test failed");
      end
      $finish;
   end

endmodule
